@@ design/ptss_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and register indexes for the pan/tilt slew sequencer.
package ptss_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int PAN_W  = 9;
  localparam int TILT_W = 8;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 10;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_INTERVAL = 2'd1;

  localparam logic [CFG_W-1:0] STEP_INTERVAL_RST = 16'd100;
  localparam logic [CFG_W-1:0] IDLE_INTERVAL_RST = 16'd950;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 8'h39;

  // pan = trunc((2000 - 11x) / 50), tilt = trunc((y - 850) / 10)
  localparam int PAN_OFFSET  = 2000;
  localparam int PAN_SCALE   = 11;
  localparam int PAN_RECIP   = 20972;
  localparam int PAN_SHIFT   = 20;
  localparam int TILT_OFFSET = 850;
  localparam int TILT_RECIP  = 6554;
  localparam int TILT_SHIFT  = 16;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PAN  = 2'd1,
    PH_TILT = 2'd2,
    PH_REST = 2'd3
  } phase_t;

  typedef struct packed {
    logic                     is_tick;
    logic signed [PAN_W-1:0]  pan_goal;
    logic signed [TILT_W-1:0] tilt_goal;
  } item_t;

endpackage

@@ design/pan_tilt_servo_slew_sequencer_unit.sv @@
`timescale 1ns / 1ps
// Top level of the pan/tilt servo slew sequencer.
//
//   channel | handshake          | carries
//   --------+--------------------+-------------------------------------------
//   in      | in_valid/in_ready  | action, six ASCII position bytes
//   out     | out_valid/out_ready| pan/tilt writes, busy, command dropped
//   cfg     | cfg_valid/cfg_ready| register index and 16-bit data
//
// One request per cycle sustained while out_ready holds high; a taken request
// passes the parse register, a queue slot and then the result register in the
// sequencer. The scale multiply sits before the parse register, the
// reciprocal divides after it.
// Reset is synchronous; the command store holds no reset and needs no sweep.
// A stalled out channel fills the queue and then holds in_ready low.
// cfg_ready is always high.
module pan_tilt_servo_slew_sequencer_unit #(
  parameter int QUEUE_DEPTH = ptss_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_action,
  input  logic [ptss_pkg::CHAR_W-1:0]          in_x_char_hundreds,
  input  logic [ptss_pkg::CHAR_W-1:0]          in_x_char_tens,
  input  logic [ptss_pkg::CHAR_W-1:0]          in_x_char_ones,
  input  logic [ptss_pkg::CHAR_W-1:0]          in_y_char_hundreds,
  input  logic [ptss_pkg::CHAR_W-1:0]          in_y_char_tens,
  input  logic [ptss_pkg::CHAR_W-1:0]          in_y_char_ones,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_pan_write_valid,
  output logic signed [ptss_pkg::PAN_W-1:0]    out_pan_angle_out,
  output logic                                 out_tilt_write_valid,
  output logic signed [ptss_pkg::TILT_W-1:0]   out_tilt_angle_out,
  output logic                                 out_busy_res,
  output logic                                 out_command_dropped,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ptss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ptss_pkg::CFG_W-1:0]           cfg_data
);

  logic            push_valid, push_ready, pop_valid, pop_ready;
  ptss_pkg::item_t push_item, pop_item;

  ptss_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_x_char_hundreds(in_x_char_hundreds),
    .in_x_char_tens    (in_x_char_tens),
    .in_x_char_ones    (in_x_char_ones),
    .in_y_char_hundreds(in_y_char_hundreds),
    .in_y_char_tens    (in_y_char_tens),
    .in_y_char_ones    (in_y_char_ones),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_item         (push_item)
  );

  ptss_link u_link (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  ptss_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .item_valid          (pop_valid),
    .item_ready          (pop_ready),
    .item                (pop_item),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pan_write_valid (out_pan_write_valid),
    .out_pan_angle_out   (out_pan_angle_out),
    .out_tilt_write_valid(out_tilt_write_valid),
    .out_tilt_angle_out  (out_tilt_angle_out),
    .out_busy_res        (out_busy_res),
    .out_command_dropped (out_command_dropped)
  );

endmodule

@@ design/ptss_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module ptss_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/ptss_front.sv @@
`timescale 1ns / 1ps
// Front end: takes requests, parses ASCII positions and maps them to servo goals.
module ptss_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [ptss_pkg::CHAR_W-1:0]   in_x_char_hundreds,
  input  logic [ptss_pkg::CHAR_W-1:0]   in_x_char_tens,
  input  logic [ptss_pkg::CHAR_W-1:0]   in_x_char_ones,
  input  logic [ptss_pkg::CHAR_W-1:0]   in_y_char_hundreds,
  input  logic [ptss_pkg::CHAR_W-1:0]   in_y_char_tens,
  input  logic [ptss_pkg::CHAR_W-1:0]   in_y_char_ones,
  output logic                          push_valid,
  input  logic                          push_ready,
  output ptss_pkg::item_t               push_item
);

  function automatic logic [ptss_pkg::POS_W-1:0] parse3(
    input logic [ptss_pkg::CHAR_W-1:0] a,
    input logic [ptss_pkg::CHAR_W-1:0] b,
    input logic [ptss_pkg::CHAR_W-1:0] c
  );
    logic da, db, dc;
    logic [ptss_pkg::POS_W-1:0] va, vb, vc;
    da = (a >= ptss_pkg::ASCII_ZERO) && (a <= ptss_pkg::ASCII_NINE);
    db = (b >= ptss_pkg::ASCII_ZERO) && (b <= ptss_pkg::ASCII_NINE);
    dc = (c >= ptss_pkg::ASCII_ZERO) && (c <= ptss_pkg::ASCII_NINE);
    va = {6'd0, a[3:0]};
    vb = {6'd0, b[3:0]};
    vc = {6'd0, c[3:0]};
    if (!da) begin
      parse3 = '0;
    end else if (!db) begin
      parse3 = va;
    end else if (!dc) begin
      parse3 = va * 10'd10 + vb;
    end else begin
      parse3 = va * 10'd100 + vb * 10'd10 + vc;
    end
  endfunction

  logic [ptss_pkg::POS_W-1:0] x_pos, y_pos;
  logic [13:0]        x_scaled;
  logic signed [14:0] pan_num;
  logic signed [10:0] tilt_num;
  logic               in_fire;

  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_tick_r;
  logic               s1_pan_neg_r;
  logic [13:0]        s1_pan_mag_r;
  logic               s1_tilt_neg_r;
  logic [9:0]         s1_tilt_mag_r;

  logic [28:0]        pan_prod;
  logic [22:0]        tilt_prod;
  logic [7:0]         pan_quo;
  logic [6:0]         tilt_quo;

  assign in_ready = !s1_valid_r || push_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    x_pos    = parse3(in_x_char_hundreds, in_x_char_tens, in_x_char_ones);
    y_pos    = parse3(in_y_char_hundreds, in_y_char_tens, in_y_char_ones);
    x_scaled = {4'd0, x_pos} * 14'(ptss_pkg::PAN_SCALE);
    pan_num  = 15'(ptss_pkg::PAN_OFFSET) - $signed({1'b0, x_scaled});
    tilt_num = $signed({1'b0, y_pos}) - 11'(ptss_pkg::TILT_OFFSET);
  end

  assign s1_valid_nxt = in_fire ? 1'b1 : (push_ready ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tick_r     <= in_action;
      s1_pan_neg_r  <= pan_num[14];
      s1_pan_mag_r  <= pan_num[14] ? 14'(-pan_num) : pan_num[13:0];
      s1_tilt_neg_r <= tilt_num[10];
      s1_tilt_mag_r <= tilt_num[10] ? 10'(-tilt_num) : tilt_num[9:0];
    end
  end

  // Divide by 50 and by 10 through reciprocal multiplies, exact over the input range
  always_comb begin
    pan_prod  = {15'd0, s1_pan_mag_r} * 29'(ptss_pkg::PAN_RECIP);
    tilt_prod = {13'd0, s1_tilt_mag_r} * 23'(ptss_pkg::TILT_RECIP);
    pan_quo   = pan_prod[ptss_pkg::PAN_SHIFT +: 8];
    tilt_quo  = tilt_prod[ptss_pkg::TILT_SHIFT +: 7];
    push_item.is_tick   = s1_tick_r;
    push_item.pan_goal  = s1_pan_neg_r ? -$signed({1'b0, pan_quo}) : $signed({1'b0, pan_quo});
    push_item.tilt_goal = s1_tilt_neg_r ? -$signed({1'b0, tilt_quo})
                                        : $signed({1'b0, tilt_quo});
  end

  assign push_valid = s1_valid_r;

endmodule

@@ design/ptss_link.sv @@
`timescale 1ns / 1ps
// Two-entry request queue between the front end and the sequencer.
module ptss_link (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  ptss_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output ptss_pkg::item_t pop_item
);

  ptss_pkg::item_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ design/ptss_back.sv @@
`timescale 1ns / 1ps
// Sequencer: command store, slew state machine, wait counter and result register.
module ptss_back #(
  parameter int QUEUE_DEPTH = ptss_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  ptss_pkg::item_t                      item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ptss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ptss_pkg::CFG_W-1:0]           cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_pan_write_valid,
  output logic signed [ptss_pkg::PAN_W-1:0]    out_pan_angle_out,
  output logic                                 out_tilt_write_valid,
  output logic signed [ptss_pkg::TILT_W-1:0]   out_tilt_angle_out,
  output logic                                 out_busy_res,
  output logic                                 out_command_dropped
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int PanW = ptss_pkg::PAN_W;
  localparam int TiltW = ptss_pkg::TILT_W;
  localparam int CmdW = PanW + TiltW;

  logic [ptss_pkg::CFG_W-1:0] step_r, idle_r;

  ptss_pkg::phase_t phase_r, phase_nxt;
  logic [ptss_pkg::CFG_W-1:0] wait_r, wait_nxt;
  logic signed [PanW-1:0]  pan_cur_r, pan_cur_nxt, pan_goal_r, pan_goal_nxt;
  logic signed [TiltW-1:0] tilt_cur_r, tilt_cur_nxt, tilt_goal_r, tilt_goal_nxt;

  logic [PtrW-1:0] rd_r, rd_nxt, wr_r, wr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            byp_r, byp_nxt;
  logic [CmdW-1:0] byp_data_r, ram_rdata, head, cmd_wdata;

  logic fire, cmd_fire, tick_fire, act, push, pop, dropped;
  logic q_full, q_empty, pollable;
  logic pan_diff, tilt_diff, hp_diff, ht_diff;
  logic signed [PanW-1:0]  head_pan, pan_step, pan_val;
  logic signed [TiltW-1:0] head_tilt, tilt_step, tilt_val;
  logic pan_wr, tilt_wr, busy;

  logic                    out_valid_r;
  logic                    out_pan_wr_r, out_tilt_wr_r, out_busy_r, out_drop_r;
  logic signed [PanW-1:0]  out_pan_r;
  logic signed [TiltW-1:0] out_tilt_r;

  assign item_ready = !out_valid_r || out_ready;
  assign fire       = item_valid && item_ready;
  assign cmd_fire   = fire && !item.is_tick;
  assign tick_fire  = fire && item.is_tick;
  assign act        = tick_fire && (wait_r == '0);

  assign q_full   = (cnt_r == CntW'(QUEUE_DEPTH));
  assign q_empty  = (cnt_r == '0);
  assign push     = cmd_fire && !q_full;
  assign dropped  = cmd_fire && q_full;
  assign pollable = phase_r inside {ptss_pkg::PH_IDLE, ptss_pkg::PH_REST};
  assign pop      = act && pollable && !q_empty;

  assign cmd_wdata = {item.tilt_goal, item.pan_goal};
  assign head      = byp_r ? byp_data_r : ram_rdata;
  assign head_pan  = head[PanW-1:0];
  assign head_tilt = head[CmdW-1:PanW];

  assign pan_diff  = (pan_cur_r != pan_goal_r);
  assign tilt_diff = (tilt_cur_r != tilt_goal_r);
  assign hp_diff   = (head_pan != pan_cur_r);
  assign ht_diff   = (head_tilt != tilt_cur_r);

  // Phase transitions
  always_comb begin
    phase_nxt = phase_r;
    if (act) begin
      case (phase_r)
        ptss_pkg::PH_PAN: begin
          if (!pan_diff) begin
            phase_nxt = tilt_diff ? ptss_pkg::PH_TILT : ptss_pkg::PH_REST;
          end
        end
        ptss_pkg::PH_TILT: begin
          if (!tilt_diff) begin
            phase_nxt = ptss_pkg::PH_REST;
          end
        end
        default: begin
          if (q_empty) begin
            phase_nxt = ptss_pkg::PH_REST;
          end else if (hp_diff) begin
            phase_nxt = ptss_pkg::PH_PAN;
          end else if (ht_diff) begin
            phase_nxt = ptss_pkg::PH_TILT;
          end else begin
            phase_nxt = ptss_pkg::PH_REST;
          end
        end
      endcase
    end
  end

  // Servo writes, angles, wait counter and command store pointers
  always_comb begin
    pan_step  = (pan_goal_r > pan_cur_r) ? pan_cur_r + PanW'(1) : pan_cur_r - PanW'(1);
    tilt_step = (tilt_goal_r > tilt_cur_r) ? tilt_cur_r + TiltW'(1) : tilt_cur_r - TiltW'(1);

    pan_wr  = act && (((phase_r == ptss_pkg::PH_PAN) && pan_diff) || (pop && hp_diff));
    tilt_wr = act && (((phase_r == ptss_pkg::PH_PAN) && !pan_diff && tilt_diff) ||
                      ((phase_r == ptss_pkg::PH_TILT) && tilt_diff) ||
                      (pop && !hp_diff && ht_diff));
    pan_val  = (phase_r == ptss_pkg::PH_PAN) ? pan_step : pan_cur_r;
    tilt_val = (phase_r == ptss_pkg::PH_TILT) ? tilt_step : tilt_cur_r;

    pan_cur_nxt  = (act && (phase_r == ptss_pkg::PH_PAN) && pan_diff) ? pan_step : pan_cur_r;
    tilt_cur_nxt = (act && (phase_r == ptss_pkg::PH_TILT) && tilt_diff) ? tilt_step
                                                                         : tilt_cur_r;
    pan_goal_nxt  = pop ? head_pan : pan_goal_r;
    tilt_goal_nxt = pop ? head_tilt : tilt_goal_r;

    wait_nxt = wait_r;
    if (tick_fire) begin
      if (wait_r != '0) begin
        wait_nxt = wait_r - 16'd1;
      end else if (phase_nxt == ptss_pkg::PH_REST) begin
        wait_nxt = idle_r;
      end else begin
        wait_nxt = step_r;
      end
    end

    busy = (wait_nxt != '0) || (phase_nxt == ptss_pkg::PH_PAN) ||
           (phase_nxt == ptss_pkg::PH_TILT);

    rd_nxt = rd_r;
    if (pop) begin
      rd_nxt = (rd_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + PtrW'(1);
    end
    wr_nxt = wr_r;
    if (push) begin
      wr_nxt = (wr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + PtrW'(1);
    end
    cnt_nxt = cnt_r + CntW'(push) - CntW'(pop);
    // A write to the slot about to be read misses the registered RAM read data, so it is bypassed
    byp_nxt = push && (wr_r == rd_nxt);
  end

  ptss_ram #(
    .WIDTH(CmdW),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_ram (
    .clk  (clk),
    .we   (push),
    .waddr(wr_r),
    .wdata(cmd_wdata),
    .raddr(rd_nxt),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ptss_pkg::STEP_INTERVAL_RST;
      idle_r      <= ptss_pkg::IDLE_INTERVAL_RST;
      phase_r     <= ptss_pkg::PH_IDLE;
      wait_r      <= '0;
      pan_cur_r   <= '0;
      tilt_cur_r  <= '0;
      pan_goal_r  <= '0;
      tilt_goal_r <= '0;
      rd_r        <= '0;
      wr_r        <= '0;
      cnt_r       <= '0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          ptss_pkg::CFG_STEP_INTERVAL: step_r <= cfg_data;
          ptss_pkg::CFG_IDLE_INTERVAL: idle_r <= cfg_data;
          default: ;
        endcase
      end
      phase_r     <= phase_nxt;
      wait_r      <= wait_nxt;
      pan_cur_r   <= pan_cur_nxt;
      tilt_cur_r  <= tilt_cur_nxt;
      pan_goal_r  <= pan_goal_nxt;
      tilt_goal_r <= tilt_goal_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      cnt_r       <= cnt_nxt;
      byp_r       <= byp_nxt;
      out_valid_r <= fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      byp_data_r <= cmd_wdata;
    end
    if (fire) begin
      out_pan_wr_r  <= pan_wr;
      out_pan_r     <= pan_wr ? pan_val : '0;
      out_tilt_wr_r <= tilt_wr;
      out_tilt_r    <= tilt_wr ? tilt_val : '0;
      out_busy_r    <= busy;
      out_drop_r    <= dropped;
    end
  end

  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_pan_write_valid  = out_pan_wr_r;
  assign out_pan_angle_out    = out_pan_r;
  assign out_tilt_write_valid = out_tilt_wr_r;
  assign out_tilt_angle_out   = out_tilt_r;
  assign out_busy_res         = out_busy_r;
  assign out_command_dropped  = out_drop_r;

endmodule

@@ design/ptss_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the slew sequencer, bound to the top level.
module ptss_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_pan_write_valid,
  input logic signed [ptss_pkg::PAN_W-1:0]  out_pan_angle_out,
  input logic                               out_tilt_write_valid,
  input logic signed [ptss_pkg::TILT_W-1:0] out_tilt_angle_out,
  input logic                               out_command_dropped
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_pan_write_valid && out_tilt_write_valid))
    else $error("pan and tilt written by the same request");

  a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_dropped |-> !out_pan_write_valid && !out_tilt_write_valid)
    else $error("dropped command caused a servo write");

  a_angle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pan_write_valid || out_pan_angle_out == '0) &&
                  (out_tilt_write_valid || out_tilt_angle_out == '0))
    else $error("angle nonzero without a write");

endmodule

bind pan_tilt_servo_slew_sequencer_unit ptss_checker u_ptss_checker (.*);
